// File: rtl/pkrb_pkg.sv
// Shared types, codes and constants of the per-key range budget table.
package pkrb_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 256;

  localparam int CMD_W     = 2;
  localparam int KEY_W     = 8;
  localparam int RANGE_W   = 64;
  localparam int BUDGET_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHARGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LIMITED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BUDGET  = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   idx;
    logic [RANGE_W-1:0] point;
    logic               ranges_present;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
  } item_t;

  typedef struct packed {
    logic [BUDGET_W-1:0] budget;
    logic                pvalid;
    logic [RANGE_W-1:0]  pstart;
    logic [RANGE_W-1:0]  pend;
  } entry_t;

endpackage

// File: rtl/pkrb_in_if.sv
// Input channel of the per-key range budget table.
interface pkrb_in_if;
  import pkrb_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key_index;
  logic [RANGE_W-1:0] range_point;
  logic               ranges_present;
  logic [RANGE_W-1:0] span_start;
  logic [RANGE_W-1:0] span_end;

  modport source (output valid, cmd, key_index, range_point, ranges_present, span_start,
                  span_end, input ready);
  modport sink (input valid, cmd, key_index, range_point, ranges_present, span_start,
                span_end, output ready);
endinterface

// File: rtl/pkrb_out_if.sv
// Result channel of the per-key range budget table.
interface pkrb_out_if;
  import pkrb_pkg::*;

  logic                valid;
  logic                ready;
  logic                allowed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, allowed, status, input ready);
  modport sink (input valid, allowed, status, output ready);
endinterface

// File: rtl/pkrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pkrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// File: rtl/pkrb_front.sv
// Front end: accepts input transactions, maps the key to a table row and queues them.
module pkrb_front #(
  parameter int TABLE_ENTRIES = pkrb_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  pkrb_in_if.sink         in_ch,
  output logic            q_valid,
  output pkrb_pkg::item_t q_item,
  input  logic            q_ready
);
  import pkrb_pkg::*;

  localparam int KEY_SPAN = 1 << KEY_W;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

  logic [KEY_W-1:0] idx_lut [KEY_SPAN];
  item_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  item_t             new_item;
  logic              push, pop;

  for (genvar g = 0; g < KEY_SPAN; g++) begin : g_lut
    assign idx_lut[g] = KEY_W'(g % TABLE_ENTRIES);
  end

  always_comb begin
    new_item.cmd            = in_ch.cmd;
    new_item.idx            = idx_lut[in_ch.key_index];
    new_item.point          = in_ch.range_point;
    new_item.ranges_present = in_ch.ranges_present;
    new_item.lo             = in_ch.span_start;
    new_item.hi             = in_ch.span_end;
  end

  assign in_ch.ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid     = (count_r != '0);
  assign q_item      = slot_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end
endmodule

// File: rtl/pkrb_back.sv
// Back end: entry read per transaction, write-back on a limited charge, result register.
module pkrb_back #(
  parameter int TABLE_ENTRIES = pkrb_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_limited,
  input  logic [pkrb_pkg::BUDGET_W-1:0] cfg_budget,
  input  logic                          q_valid,
  input  pkrb_pkg::item_t               q_item,
  output logic                          q_ready,
  pkrb_out_if.source                    out_ch
);
  import pkrb_pkg::*;

  localparam int MEM_DEPTH = (TABLE_ENTRIES < (1 << KEY_W)) ? TABLE_ENTRIES : (1 << KEY_W);
  localparam int IDX_W     = $clog2(MEM_DEPTH);
  localparam int ENTRY_W   = $bits(entry_t);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_r, state_nxt;
  item_t                cur_r;
  logic [MEM_DEPTH-1:0] present_r, present_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 allowed_r, allowed_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic [ENTRY_W-1:0]   rd_raw;
  entry_t               rd_entry, base, upd;
  logic [IDX_W-1:0]     cur_idx;
  logic                 is_present, overlap, exhausted, chk_allowed;
  logic                 fire, wr_en, rd_en;

  pkrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_idx),
    .wr_data (upd),
    .rd_en   (rd_en),
    .rd_addr (q_item.idx[IDX_W-1:0]),
    .rd_data (rd_raw)
  );

  assign rd_entry   = rd_raw;
  assign cur_idx    = cur_r.idx[IDX_W-1:0];
  assign is_present = present_r[cur_idx];
  assign q_ready    = (state_r == S_IDLE);
  assign rd_en      = q_valid && q_ready;
  assign fire       = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    base = rd_entry;
    if (!is_present) begin
      base.budget = cfg_budget;
      base.pvalid = 1'b0;
    end
    overlap   = (cur_r.hi > base.pstart) && (cur_r.lo < base.pend);
    upd       = base;
    exhausted = 1'b0;
    if (!base.pvalid) begin
      if (base.budget == '0) begin
        exhausted = 1'b1;
      end else begin
        upd.budget = base.budget - 1'b1;
        upd.pvalid = 1'b1;
        upd.pstart = cur_r.lo;
        upd.pend   = cur_r.hi;
      end
    end else if (overlap) begin
      if (base.budget == '0) begin
        exhausted = 1'b1;
      end else begin
        upd.budget = base.budget - 1'b1;
        upd.pstart = (base.pstart > cur_r.lo) ? base.pstart : cur_r.lo;
        upd.pend   = (base.pend < cur_r.hi) ? base.pend : cur_r.hi;
      end
    end else begin
      upd.pstart = (base.pstart < cur_r.lo) ? base.pstart : cur_r.lo;
      upd.pend   = (base.pend > cur_r.hi) ? base.pend : cur_r.hi;
    end
    if (!exhausted && upd.pstart == '0 && upd.pend == '1) begin
      upd.pvalid = 1'b0;
    end
  end

  always_comb begin
    if (!is_present) begin
      chk_allowed = !cfg_limited || (cfg_budget != '0);
    end else if (rd_entry.budget != '0) begin
      chk_allowed = 1'b1;
    end else if (rd_entry.pvalid) begin
      chk_allowed = (cur_r.point < rd_entry.pstart) || (cur_r.point >= rd_entry.pend);
    end else begin
      chk_allowed = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    allowed_nxt   = allowed_r;
    status_nxt    = status_r;
    wr_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          allowed_nxt   = 1'b0;
          status_nxt    = ST_OK;
          case (cur_r.cmd)
            CMD_CHECK: begin
              allowed_nxt = chk_allowed;
            end
            CMD_CHARGE: begin
              if (!cur_r.ranges_present) begin
                status_nxt = ST_EMPTY;
              end else if (cfg_limited) begin
                wr_en                = 1'b1;
                present_nxt[cur_idx] = 1'b1;
                status_nxt           = exhausted ? ST_EXHAUSTED : ST_OK;
              end
            end
            CMD_EXPIRE: begin
              present_nxt[cur_idx] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    allowed_r <= allowed_nxt;
    status_r  <= status_nxt;
    if (rd_en) begin
      cur_r <= q_item;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.allowed = allowed_r;
  assign out_ch.status  = status_r;
endmodule

// File: rtl/per_key_range_budget_table.sv
// Top level of the per-key range budget table.
//
// Transactions enter on in_ch (valid/ready) and carry a command: check a
// point against a key's budget, charge a span to a key, or expire a key.
// Every transaction gives exactly one result on out_ch (allowed, status),
// in the order the transactions were accepted.
// A front end takes up to two transactions into a queue; the back end reads
// the key's entry from the entry RAM for each transaction and, for a charge
// while limiting is on, updates it and writes it back. A transaction passes
// through the back-end states IDLE, where the registered RAM read is issued,
// and EXEC, where the entry is updated and the result register is loaded;
// the back end takes no new transaction until the current one leaves EXEC.
// When the receiver stalls, the result register holds its transaction and
// the queue keeps filling until it is full, after which in_ch.ready drops.
// The configuration registers must be written through cfg_wr_en, cfg_index
// and cfg_wr_data only while no transaction is in flight; the block itself
// does not enforce this. Reset clears the configuration and marks every table
// entry absent at once; in_ch.ready is high as soon as reset is released.
module per_key_range_budget_table #(
  parameter int TABLE_ENTRIES = pkrb_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pkrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pkrb_pkg::CFG_W-1:0]     cfg_wr_data,
  pkrb_in_if.sink                        in_ch,
  pkrb_out_if.source                     out_ch
);
  import pkrb_pkg::*;

  logic                cfg_limited_r;
  logic [BUDGET_W-1:0] cfg_budget_r;
  logic                q_valid, q_ready;
  item_t               q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limited_r <= 1'b0;
      cfg_budget_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEFAULT_LIMITED: cfg_limited_r <= cfg_wr_data[0];
        REG_DEFAULT_BUDGET:  cfg_budget_r  <= cfg_wr_data[BUDGET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pkrb_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  pkrb_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_limited (cfg_limited_r),
    .cfg_budget  (cfg_budget_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready),
    .out_ch      (out_ch)
  );
endmodule
